[hdl/nkb_pkg.sv]
// ----------------------------------------------------------------------------
// nkb_pkg - shared types and constants of the keyword blocker
// Keyword table, window geometry and per-position compare constants.
// ----------------------------------------------------------------------------
package nkb_pkg;

  localparam int unsigned WINDOW_CHARS = 7;
  localparam int unsigned HIST_DEPTH   = WINDOW_CHARS - 1;
  localparam int unsigned KW_COUNT     = 6;
  localparam int unsigned CHAR_W       = 8;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_FOLD  = 8'h20;
  localparam logic [CHAR_W-1:0] LIMIT_RST  = 8'hFF;

  typedef logic [CHAR_W-1:0]                char_t;
  typedef logic [KW_COUNT-1:0][CHAR_W-1:0]  kw_bytes_t;
  typedef logic [KW_COUNT-1:0]              kw_mask_t;

  // Keywords, right-justified: the last letter sits in the low byte, so a
  // window position maps to the same byte lane for every keyword.
  localparam logic [WINDOW_CHARS*CHAR_W-1:0] KW_TEXT [KW_COUNT] = '{
    "delete", "remove", "kill", "destroy", "format", "rm -rf"
  };
  localparam int unsigned KW_LEN [KW_COUNT] = '{6, 6, 4, 7, 6, 6};

  // Expected byte of each keyword at a window position (0 = oldest)
  function automatic kw_bytes_t win_expect(input int unsigned pos);
    kw_bytes_t r;
    for (int unsigned k = 0; k < KW_COUNT; k++) begin
      r[k] = KW_TEXT[k][(WINDOW_CHARS-1-pos)*CHAR_W +: CHAR_W];
    end
    return r;
  endfunction

  // Which keywords reach back as far as a window position
  function automatic kw_mask_t win_care(input int unsigned pos);
    kw_mask_t r;
    for (int unsigned k = 0; k < KW_COUNT; k++) begin
      r[k] = (pos >= WINDOW_CHARS - KW_LEN[k]);
    end
    return r;
  endfunction

endpackage

[hdl/nkb_cell.sv]
// ----------------------------------------------------------------------------
// nkb_cell - one history cell of the keyword window
// Holds one kept character, shifts it on to its neighbor, and compares it
// against the keyword letters expected at its window position.
// ----------------------------------------------------------------------------
module nkb_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  logic               shift_i,
  input  nkb_pkg::char_t     char_i,
  input  nkb_pkg::kw_bytes_t expect_i,
  input  nkb_pkg::kw_mask_t  care_i,
  output nkb_pkg::char_t     char_o,
  output nkb_pkg::kw_mask_t  hit_o
);
  import nkb_pkg::*;

  char_t char_q, char_d;

  // clear wins over shift: a query end wipes the window
  always_comb begin
    char_d = char_q;
    if (clear_i) begin
      char_d = CHAR_NUL;
    end else if (shift_i) begin
      char_d = char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_q <= CHAR_NUL;
    end else begin
      char_q <= char_d;
    end
  end

  // per keyword: matches here, or keyword too short to reach this cell
  always_comb begin
    for (int unsigned k = 0; k < KW_COUNT; k++) begin
      hit_o[k] = !care_i[k] || (char_q == expect_i[k]);
    end
  end

  assign char_o = char_q;

endmodule

[hdl/normalized_keyword_blocker_unit.sv]
// ----------------------------------------------------------------------------
// normalized_keyword_blocker_unit - keyword filter over a normalized query
// Folds case, collapses blanks, caps the kept length and matches the last
// seven kept characters against a fixed keyword list.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   in       | in_valid_i/in_ready_o, char_code_i,       | request in
//            | has_char_i, last_i                        |
//   out      | out_valid_o/out_ready_i, blocked_o        | result out
//   cfg      | cfg_we_i, cfg_wdata_i (output_limit)      | write only
//
// One request per cycle while in_ready_o is high. The window compare and state
// update happen in the accepting cycle; a last request shows its result on the
// next cycle. Reset sets output_limit to 255 and clears the window and query
// state. in_ready_o drops only while a result is held with out_ready_i low.
// ----------------------------------------------------------------------------
module normalized_keyword_blocker_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  nkb_pkg::char_t cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  nkb_pkg::char_t char_code_i,
  input  logic           has_char_i,
  input  logic           last_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           blocked_o
);
  import nkb_pkg::*;

  char_t     limit_q;
  char_t     count_q, count_d;
  logic      blank_q, blank_d;
  logic      seen_q, seen_d;
  logic      ended_q, ended_d;
  logic      out_valid_q, out_valid_d;
  logic      blocked_q, blocked_d;

  logic      accept;
  logic      live;
  logic      is_blank;
  logic      keep;
  logic      query_end;
  char_t     folded;
  char_t     keep_char;
  char_t     cell_out [HIST_DEPTH];
  kw_mask_t  cell_hit [HIST_DEPTH];
  kw_mask_t  new_hit;
  kw_mask_t  kw_match;
  kw_bytes_t new_expect;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign query_end  = accept && last_i;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // normalize: fold upper case, map tab/space to one space
  assign folded   = ((char_code_i >= CHAR_UP_A) && (char_code_i <= CHAR_UP_Z))
                    ? (char_code_i | CASE_FOLD) : char_code_i;
  assign is_blank = (char_code_i == CHAR_SPACE) || (char_code_i == CHAR_TAB);
  assign live     = accept && has_char_i && !ended_q && (char_code_i != CHAR_NUL)
                    && (count_q < limit_q);
  assign keep     = live && (!is_blank || (!blank_q && (count_q != '0)));
  assign keep_char = is_blank ? CHAR_SPACE : folded;

  // history chain, oldest character in cell 0
  for (genvar p = 0; p < HIST_DEPTH; p++) begin : g_cell
    char_t cell_in;
    if (p == HIST_DEPTH - 1) begin : g_head
      assign cell_in = keep_char;
    end else begin : g_body
      assign cell_in = cell_out[p+1];
    end
    nkb_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .clear_i  (query_end),
      .shift_i  (keep),
      .char_i   (cell_in),
      .expect_i (win_expect(p)),
      .care_i   (win_care(p)),
      .char_o   (cell_out[p]),
      .hit_o    (cell_hit[p])
    );
  end

  // newest window position is the character being kept now
  assign new_expect = win_expect(WINDOW_CHARS - 1);
  always_comb begin
    for (int unsigned k = 0; k < KW_COUNT; k++) begin
      new_hit[k] = (keep_char == new_expect[k]);
    end
  end

  always_comb begin
    kw_match = new_hit;
    for (int unsigned p = 0; p < HIST_DEPTH; p++) begin
      kw_match = kw_match & cell_hit[p];
    end
  end

  // query state
  always_comb begin
    count_d = count_q;
    blank_d = blank_q;
    seen_d  = seen_q || (keep && (kw_match != '0));
    ended_d = ended_q;
    if (accept && has_char_i && !ended_q && (char_code_i == CHAR_NUL)) begin
      ended_d = 1'b1;
    end
    if (live) begin
      blank_d = is_blank;
    end
    if (keep) begin
      count_d = count_q + 8'd1;
    end
    blocked_d = seen_d;
    if (query_end) begin
      count_d = '0;
      blank_d = 1'b0;
      seen_d  = 1'b0;
      ended_d = 1'b0;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (query_end) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      blank_q     <= 1'b0;
      seen_q      <= 1'b0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      blank_q     <= blank_d;
      seen_q      <= seen_d;
      ended_q     <= ended_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_end) begin
      blocked_q <= blocked_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign blocked_o   = blocked_q;

endmodule

[hdl/nkb_checker.sv]
// ----------------------------------------------------------------------------
// nkb_checker - port-level checks of the keyword blocker
// Watches the top-level handshakes and result timing; bound to the top.
// ----------------------------------------------------------------------------
module nkb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic has_char_i,
  input logic last_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic blocked_o
);
  import nkb_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(blocked_o))
    else $error("result changed while stalled");

  // a last request always yields a result next cycle
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_i |=> out_valid_o)
    else $error("no result after last request");

  // requests that do not end a query produce nothing
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_acc && !last_i |=> !out_valid_o)
    else $error("result without last request");

  // an empty query right after another query end is never blocked
  a_empty_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_i) ##1 (in_acc && last_i && !has_char_i) |=> !blocked_o)
    else $error("empty query reported blocked");

endmodule

bind normalized_keyword_blocker_unit nkb_checker u_nkb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .has_char_i  (has_char_i),
  .last_i      (last_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .blocked_o   (blocked_o)
);
